@@ design/nfa_pkg.sv @@
// shared types and constants of the next-fit id allocator
package nfa_pkg;

	localparam int ID_W         = 11;
	localparam int STATUS_W     = 2;
	localparam int DEF_CAPACITY = 1024;
	localparam int WORD_W       = 32;
	localparam int BIT_W        = 5;

	localparam logic [ID_W-1:0] ACTIVE_SIZE_RST = 11'd1024;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic clear_step;
		logic accept;
		logic mod_start;
		logic scan_start;
		logic scan_step;
		logic grant;
		logic set_full;
		logic free_rd;
		logic free_wr;
		logic out_load;
	} nfa_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic req_free;
		logic early_out;
		logic div_busy;
		logic hit;
		logic scan_miss;
	} nfa_sts_t;

endpackage

@@ design/next_fit_id_allocator.sv @@
// top level of the next-fit id allocator: controller, datapath and config register port
// allocate: after the transfer a restoring modulo pass runs when the search start is at or
//   past the size, then w bitmap words are read and searched, w from 1 to words + 1, and the
//   result is registered; free: the word is read, then written; rejected: no bitmap access
// one request at a time, the next transfer is taken the cycle after the result is registered
// reset clears all ceil(CAPACITY/32) bitmap words (32 at 1024 ids) with one word written per
//   cycle, in_ready stays low during that pass; active size resets to 1024
module next_fit_id_allocator #(
	parameter int CAPACITY = nfa_pkg::DEF_CAPACITY
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [nfa_pkg::ID_W-1:0]      id,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [nfa_pkg::ID_W-1:0]      granted_id,
	output logic [nfa_pkg::STATUS_W-1:0]  status,
	// active size register write
	input  logic                          cfg_we,
	input  logic [nfa_pkg::ID_W-1:0]      cfg_wdata
);
	import nfa_pkg::*;

	// command and status between the state machine and the datapath
	nfa_cmd_t cmd;
	nfa_sts_t sts;

	// sequencer: clearing pass, request decode, scan loop, result hand-off
	nfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// bitmap words, next-fit cursor, modulo unit and result registers
	nfa_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.kind       (kind),
		.id         (id),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.granted_id (granted_id),
		.status     (status)
	);

endmodule

@@ design/nfa_ctrl.sv @@
// controller state machine of the next-fit id allocator
module nfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  nfa_pkg::nfa_sts_t sts,
	output nfa_pkg::nfa_cmd_t cmd
);
	import nfa_pkg::*;

	localparam logic [2:0] ST_CLEAR   = 3'd0;
	localparam logic [2:0] ST_IDLE    = 3'd1;
	localparam logic [2:0] ST_MOD     = 3'd2;
	localparam logic [2:0] ST_SCAN    = 3'd3;
	localparam logic [2:0] ST_FREE_RD = 3'd4;
	localparam logic [2:0] ST_FREE_WR = 3'd5;
	localparam logic [2:0] ST_RESP    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       out_valid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_done) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.early_out) begin
						state_nx = ST_RESP;
					end else if (sts.req_free) begin
						state_nx = ST_FREE_RD;
					end else begin
						cmd.mod_start = 1'b1;
						state_nx      = ST_MOD;
					end
				end
			end
			ST_MOD: begin
				if (!sts.div_busy) begin
					cmd.scan_start = 1'b1;
					state_nx       = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.hit) begin
					cmd.grant = 1'b1;
					state_nx  = ST_RESP;
				end else if (sts.scan_miss) begin
					cmd.set_full = 1'b1;
					state_nx     = ST_RESP;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_FREE_RD: begin
				cmd.free_rd = 1'b1;
				state_nx    = ST_FREE_WR;
			end
			ST_FREE_WR: begin
				cmd.free_wr = 1'b1;
				state_nx    = ST_RESP;
			end
			ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ design/nfa_datapath.sv @@
// bitmap store, search datapath and result registers of the id allocator
module nfa_datapath #(
	parameter int CAPACITY = nfa_pkg::DEF_CAPACITY
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nfa_pkg::nfa_cmd_t             cmd,
	output nfa_pkg::nfa_sts_t             sts,
	input  logic                          kind,
	input  logic [nfa_pkg::ID_W-1:0]      id,
	input  logic                          cfg_we,
	input  logic [nfa_pkg::ID_W-1:0]      cfg_wdata,
	output logic [nfa_pkg::ID_W-1:0]      granted_id,
	output logic [nfa_pkg::STATUS_W-1:0]  status
);
	import nfa_pkg::*;

	localparam int NWORDS  = (CAPACITY + WORD_W - 1) / WORD_W;
	localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int IDX_W   = WADDR_W + BIT_W;
	localparam int CMP_W   = (IDX_W + 1 > ID_W) ? IDX_W + 1 : ID_W;
	localparam int CNT_W   = $clog2(IDX_W);
	localparam int HW_W    = CMP_W - BIT_W;

	// bitmap store, one row per word
	logic [WORD_W-1:0]   mem_q [NWORDS];
	logic [WORD_W-1:0]   rdata_s1;

	logic [ID_W-1:0]     active_size_q;
	logic [CMP_W-1:0]    size;
	logic [CMP_W-1:0]    size_m1;
	logic [WADDR_W-1:0]  clr_q;

	logic [IDX_W-1:0]    ss_q;
	logic [IDX_W-1:0]    from_q;
	logic [CMP_W-1:0]    rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                div_busy_q;
	logic [CMP_W:0]      div_t;
	logic [CMP_W:0]      div_sub;
	logic [CMP_W-1:0]    rem_nx;

	logic [WADDR_W-1:0]  rd_w_q;
	logic                rd_p_q;
	logic                iss_q;
	logic                rd_last;
	logic                rd_fire;
	logic                rd_en;
	logic [WADDR_W-1:0]  rd_addr;
	logic [WADDR_W-1:0]  from_w;
	logic [WADDR_W-1:0]  last_w;

	logic                ev_v_s1;
	logic [WADDR_W-1:0]  ev_w_s1;
	logic                ev_p_s1;
	logic                ev_last_s1;

	logic [IDX_W-1:0]    lo;
	logic [CMP_W-1:0]    hi;
	logic [WADDR_W-1:0]  lo_w;
	logic [BIT_W-1:0]    lo_b;
	logic [HW_W-1:0]     hi_w;
	logic [BIT_W-1:0]    hi_b;
	logic [HW_W-1:0]     ev_w_ext;
	logic [WORD_W-1:0]   ge_mask;
	logic [WORD_W-1:0]   lt_mask;
	logic [WORD_W-1:0]   cand;
	logic                hit;
	logic [BIT_W-1:0]    enc_b;
	logic [WORD_W-1:0]   set_onehot;
	logic [IDX_W-1:0]    pos;
	logic [IDX_W:0]      pos1;

	logic [ID_W-1:0]     id_q;
	logic [CMP_W-1:0]    id_m1;
	logic [WADDR_W-1:0]  fr_w;
	logic [WORD_W-1:0]   fr_onehot;

	logic [STATUS_W-1:0] early_st;
	logic [ID_W-1:0]     res_id_q;
	logic [STATUS_W-1:0] res_st_q;
	logic [ID_W-1:0]     granted_id_q;
	logic [STATUS_W-1:0] status_q;

	// active size clamped to capacity
	always_comb begin
		if (CMP_W'(active_size_q) > CMP_W'(CAPACITY)) begin
			size = CMP_W'(CAPACITY);
		end else begin
			size = CMP_W'(active_size_q);
		end
	end

	assign size_m1 = size - CMP_W'(1);
	assign last_w  = size_m1[IDX_W-1:BIT_W];
	assign from_w  = from_q[IDX_W-1:BIT_W];

	// request check at accept
	always_comb begin
		if (kind == KIND_ALLOC) begin
			early_st = (size == '0) ? STATUS_FULL : STATUS_OK;
		end else if (id == '0 || CMP_W'(id) > size) begin
			early_st = STATUS_RANGE;
		end else begin
			early_st = STATUS_OK;
		end
	end

	// restoring remainder step for search start modulo size
	assign div_t   = {rem_q, ss_q[cnt_q]};
	assign div_sub = div_t - {1'b0, size};
	assign rem_nx  = (div_t >= {1'b0, size}) ? div_sub[CMP_W-1:0] : div_t[CMP_W-1:0];

	// scan cursor: wraps from last word to word 0, ends on the start word; a scan from slot 0 ends on the last word
	assign rd_last = rd_p_q ? (rd_w_q == from_w) : ((rd_w_q == last_w) && (from_q == '0));
	assign rd_fire = cmd.scan_step && iss_q;
	assign rd_en   = rd_fire || cmd.free_rd;

	assign id_m1     = CMP_W'(id_q) - CMP_W'(1);
	assign fr_w      = id_m1[IDX_W-1:BIT_W];
	assign fr_onehot = WORD_W'(1) << id_m1[BIT_W-1:0];
	assign rd_addr   = cmd.free_rd ? fr_w : rd_w_q;

	// window of slots searched in the word under evaluation
	always_comb begin
		if (ev_p_s1) begin
			lo = '0;
			hi = CMP_W'(from_q);
		end else begin
			lo = from_q;
			hi = size;
		end
	end

	assign lo_w     = lo[IDX_W-1:BIT_W];
	assign lo_b     = lo[BIT_W-1:0];
	assign hi_w     = hi[CMP_W-1:BIT_W];
	assign hi_b     = hi[BIT_W-1:0];
	assign ev_w_ext = HW_W'(ev_w_s1);

	always_comb begin
		if (ev_w_s1 > lo_w) begin
			ge_mask = '1;
		end else if (ev_w_s1 == lo_w) begin
			ge_mask = {WORD_W{1'b1}} << lo_b;
		end else begin
			ge_mask = '0;
		end
		if (ev_w_ext < hi_w) begin
			lt_mask = '1;
		end else if (ev_w_ext == hi_w) begin
			lt_mask = ~({WORD_W{1'b1}} << hi_b);
		end else begin
			lt_mask = '0;
		end
	end

	assign cand = ~rdata_s1 & ge_mask & lt_mask;
	assign hit  = ev_v_s1 && (cand != '0);

	// lowest clear slot in the window
	always_comb begin
		enc_b = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (cand[i]) begin
				enc_b = BIT_W'(i);
			end
		end
	end

	assign set_onehot = WORD_W'(1) << enc_b;
	assign pos        = {ev_w_s1, enc_b};
	assign pos1       = (IDX_W + 1)'(pos) + (IDX_W + 1)'(1);

	// bitmap store
	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			mem_q[clr_q] <= '0;
		end else if (cmd.grant) begin
			mem_q[ev_w_s1] <= rdata_s1 | set_onehot;
		end else if (cmd.free_wr) begin
			mem_q[fr_w] <= rdata_s1 & ~fr_onehot;
		end
		if (rd_en) begin
			rdata_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_size_q <= ACTIVE_SIZE_RST;
			clr_q         <= '0;
			ss_q          <= '0;
			div_busy_q    <= 1'b0;
			iss_q         <= 1'b0;
			ev_v_s1       <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_size_q <= cfg_wdata;
			end
			if (cmd.clear_step) begin
				clr_q <= clr_q + WADDR_W'(1);
			end
			if (cmd.grant) begin
				ss_q <= (pos1 >= (IDX_W + 1)'(CAPACITY)) ? '0 : pos1[IDX_W-1:0];
			end
			if (cmd.mod_start) begin
				div_busy_q <= (CMP_W'(ss_q) >= size);
			end else if (div_busy_q && cnt_q == '0) begin
				div_busy_q <= 1'b0;
			end
			if (cmd.scan_start) begin
				iss_q <= 1'b1;
			end else if (rd_fire && rd_last) begin
				iss_q <= 1'b0;
			end
			ev_v_s1 <= rd_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_start) begin
			from_q <= ss_q;
			rem_q  <= '0;
			cnt_q  <= CNT_W'(IDX_W - 1);
		end else if (div_busy_q) begin
			rem_q <= rem_nx;
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == '0) begin
				from_q <= rem_nx[IDX_W-1:0];
			end
		end
		if (cmd.scan_start) begin
			rd_w_q <= from_w;
			rd_p_q <= 1'b0;
		end else if (rd_fire) begin
			if (!rd_p_q && rd_w_q == last_w) begin
				rd_w_q <= '0;
				rd_p_q <= 1'b1;
			end else begin
				rd_w_q <= rd_w_q + WADDR_W'(1);
			end
		end
		ev_w_s1    <= rd_w_q;
		ev_p_s1    <= rd_p_q;
		ev_last_s1 <= rd_last;
		if (cmd.accept) begin
			id_q     <= id;
			res_id_q <= '0;
			res_st_q <= early_st;
		end
		if (cmd.grant) begin
			res_id_q <= ID_W'(pos1);
		end
		if (cmd.set_full) begin
			res_st_q <= STATUS_FULL;
		end
		if (cmd.out_load) begin
			granted_id_q <= res_id_q;
			status_q     <= res_st_q;
		end
	end

	always_comb begin
		sts            = '0;
		sts.clear_done = (clr_q == WADDR_W'(NWORDS - 1));
		sts.req_free   = (kind == KIND_FREE);
		sts.early_out  = (early_st != STATUS_OK);
		sts.div_busy   = div_busy_q;
		sts.hit        = hit;
		sts.scan_miss  = ev_v_s1 && ev_last_s1 && !hit;
	end

	assign granted_id = granted_id_q;
	assign status     = status_q;

endmodule

@@ design/nfa_checker.sv @@
// port-level checks of the next-fit id allocator and their bind
module nfa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [nfa_pkg::ID_W-1:0]      granted_id,
	input logic [nfa_pkg::STATUS_W-1:0]  status
);
	import nfa_pkg::*;

	// one request at a time: busy right after a transfer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one in flight");

	// failed or rejected requests grant nothing
	a_fail_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_OK |-> granted_id == '0)
		else $error("id granted with error status");

	// only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STATUS_OK || status == STATUS_FULL || status == STATUS_RANGE))
		else $error("undefined status code");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(granted_id) && $stable(status))
		else $error("result changed while stalled");

endmodule

bind next_fit_id_allocator nfa_checker u_nfa_checker (.*);

@@ test/next_fit_id_allocator_test.sv @@
// self-checking testbench of the next-fit id allocator with its own bitmap predictor
module next_fit_id_allocator_test;
	import nfa_pkg::*;

	localparam int CAPACITY     = DEF_CAPACITY;
	localparam int ID_MAX       = 1024;
	localparam int RANDOM_ITEMS = 800;
	// a full allocate scans every word plus the modulo pass
	localparam int SETTLE_CYCLES = 60;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [ID_W-1:0]     granted;
		logic [STATUS_W-1:0] st;
	} result_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_ready;
	logic                kind       = KIND_ALLOC;
	logic [ID_W-1:0]     id         = '0;
	logic                out_valid;
	logic                out_ready  = 1'b0;
	logic [ID_W-1:0]     granted_id;
	logic [STATUS_W-1:0] status;
	logic                cfg_we     = 1'b0;
	logic [ID_W-1:0]     cfg_wdata  = '0;

	// predictor state: in-use bitmap, next search slot and the active size register
	bit [CAPACITY-1:0] in_use;
	int                search_start;
	logic [ID_W-1:0]   active_size;

	// results still owed by the block, oldest first
	result_t expected_grants[$];
	result_t oldest;

	int  mismatches  = 0;
	int  cycle_count = 0;
	int  stall_left  = 0;
	bit  src_idles   = 1'b1;
	bit  sink_stalls = 1'b1;

	next_fit_id_allocator DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.id         (id),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.granted_id (granted_id),
		.status     (status),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always #5 clk = ~clk;

	// runaway guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_grants.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// gap lengths: mostly short, now and then long
	function automatic int pick_gap();
		if ($urandom_range(0, 19) < 16)
			return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	// result side back-pressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
			stall_left <= pick_gap() - 1;
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// compare every result transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_grants.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("result with none expected: granted_id %0d status %0d",
						granted_id, status);
			end else begin
				oldest = expected_grants.pop_front();
				if (granted_id !== oldest.granted || status !== oldest.st) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("mismatch: expected granted_id %0d status %0d, got granted_id %0d status %0d",
							oldest.granted, oldest.st, granted_id, status);
				end
			end
		end
	end

	// first clear slot in [lo, hi), hi when there is none
	function automatic int first_free(input int lo, input int hi);
		for (int i = lo; i < hi; i++)
			if (!in_use[i])
				return i;
		return hi;
	endfunction

	// next-fit allocation and free on the predictor state
	function automatic result_t next_fit_predict(input logic req_kind,
		input logic [ID_W-1:0] req_id);
		result_t r;
		int      size;
		int      from;
		int      pos;
		size      = (int'(active_size) > CAPACITY) ? CAPACITY : int'(active_size);
		r.granted = '0;
		r.st      = STATUS_OK;
		if (req_kind == KIND_ALLOC) begin
			if (size == 0) begin
				r.st = STATUS_FULL;
			end else begin
				// a shrunken size can leave the search start past the end
				from = search_start % size;
				pos  = first_free(from, size);
				if (pos == size) begin
					pos = first_free(0, from);
					if (pos == from)
						pos = size;
				end
				if (pos == size) begin
					r.st = STATUS_FULL;
				end else begin
					in_use[pos]  = 1'b1;
					search_start = (pos + 1 >= CAPACITY) ? 0 : pos + 1;
					r.granted    = ID_W'(pos + 1);
				end
			end
		end else if (req_id == 0 || int'(req_id) > size) begin
			r.st = STATUS_RANGE;
		end else begin
			// freeing an id that is already clear changes nothing
			in_use[req_id - 1] = 1'b0;
		end
		return r;
	endfunction

	// an id in use within the active range when there is one, else a random id in that range (0 to ID_MAX at size 0)
	function automatic logic [ID_W-1:0] pick_used_id();
		int size;
		int start;
		int s;
		size = (int'(active_size) > CAPACITY) ? CAPACITY : int'(active_size);
		if (size == 0)
			return ID_W'($urandom_range(0, ID_MAX));
		start = $urandom_range(0, size - 1);
		for (int j = 0; j < size; j++) begin
			s = (start + j) % size;
			if (in_use[s])
				return ID_W'(s + 1);
		end
		return ID_W'($urandom_range(1, size));
	endfunction

	// one request transfer; valid stays high when the next request follows at once
	task automatic issue_request(input logic req_kind, input logic [ID_W-1:0] req_id);
		int gap;
		in_valid <= 1'b1;
		kind     <= req_kind;
		id       <= req_id;
		do @(posedge clk); while (!in_ready);
		expected_grants.push_back(next_fit_predict(req_kind, req_id));
		gap = (src_idles && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid, collect all owed results, then let the block settle
	task automatic wait_until_idle();
		in_valid <= 1'b0;
		while (expected_grants.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// active size register write, only with the block idle
	task automatic set_active_size(input logic [ID_W-1:0] value);
		wait_until_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		active_size = value;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// default size after reset, free of unused ids and range edges
	task automatic test_reset_defaults();
		issue_request(KIND_ALLOC, 11'd0);
		issue_request(KIND_ALLOC, 11'd2047);
		issue_request(KIND_FREE, 11'd2);
		issue_request(KIND_FREE, 11'd2);
		issue_request(KIND_FREE, 11'd0);
		issue_request(KIND_FREE, 11'd1024);
	endtask

	// one id, no ids, and a size beyond the bitmap
	task automatic test_size_extremes();
		set_active_size(11'd1);
		issue_request(KIND_ALLOC, 11'd0);
		issue_request(KIND_ALLOC, 11'd0);
		issue_request(KIND_FREE, 11'd1);
		issue_request(KIND_ALLOC, 11'd0);
		issue_request(KIND_FREE, 11'd2);
		set_active_size(11'd0);
		issue_request(KIND_ALLOC, 11'd0);
		issue_request(KIND_FREE, 11'd1);
		set_active_size(11'd2047);
		issue_request(KIND_ALLOC, 11'd0);
		issue_request(KIND_FREE, 11'd1024);
	endtask

	// search start past a shrunken size, bits above it kept until it grows
	task automatic test_shrink_wrap();
		set_active_size(11'd1024);
		repeat (3) issue_request(KIND_ALLOC, 11'd0);
		set_active_size(11'd2);
		issue_request(KIND_ALLOC, 11'd0);
		issue_request(KIND_ALLOC, 11'd0);
		issue_request(KIND_FREE, 11'd3);
		set_active_size(11'd1024);
		issue_request(KIND_ALLOC, 11'd0);
	endtask

	// size for one random phase, small sizes favored so full and wrap come often
	function automatic logic [ID_W-1:0] pick_phase_size();
		int roll;
		roll = $urandom_range(0, 9);
		case (roll)
			0: return '0;
			1: return ID_W'($urandom_range(ID_MAX + 1, 2047));
			2: return ID_W'(ID_MAX);
			7, 8: return ID_W'($urandom_range(9, 70));
			9: return ID_W'($urandom_range(71, ID_MAX - 1));
			default: return ID_W'($urandom_range(1, 8));
		endcase
	endfunction

	// phases of mixed traffic, each under its own size and idling mode
	task automatic test_random_traffic();
		int sent;
		int roll;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			set_active_size(pick_phase_size());
			src_idles   = ($urandom_range(0, 3) != 0);
			sink_stalls = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(30, 90)) begin
				roll = $urandom_range(0, 99);
				if (roll < 55)
					issue_request(KIND_ALLOC, ID_W'($urandom_range(0, ID_MAX)));
				else if (roll < 85)
					issue_request(KIND_FREE, pick_used_id());
				else
					issue_request(KIND_FREE, ID_W'($urandom_range(0, ID_MAX)));
				sent++;
			end
		end
	endtask

	// fill the whole bitmap: top slot wraps the search start, then full at capacity
	task automatic test_fill_capacity();
		set_active_size(11'd1024);
		src_idles   = 1'b0;
		sink_stalls = 1'b0;
		while (!(&in_use))
			issue_request(KIND_ALLOC, ID_W'($urandom_range(0, ID_MAX)));
		src_idles   = 1'b1;
		sink_stalls = 1'b1;
		issue_request(KIND_ALLOC, 11'd0);
		repeat (20) begin
			issue_request(KIND_FREE, ID_W'($urandom_range(1, ID_MAX)));
			issue_request(KIND_ALLOC, 11'd0);
		end
	endtask

	initial begin
		active_size  = ACTIVE_SIZE_RST;
		search_start = 0;
		in_use       = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// the bitmap clearing pass holds in_ready low
		do @(posedge clk); while (!in_ready);

		test_reset_defaults();
		test_size_extremes();
		test_shrink_wrap();
		test_random_traffic();
		test_fill_capacity();

		wait_until_idle();
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
